>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/lip_pkg.sv
// Package with the constants of the line intersection block.
package lip_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int THR_WIDTH       = 32;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd42950;

endpackage

>>> rtl/core/line_intersection_point.sv
// Top level of the pipelined intersection of two lines given by point pairs.
//
// Usage: one transfer on the req_ channel carries the two points of each of two
// lines in signed fixed point. One transfer on the rsp_ channel returns the
// crossing point, found (low when the lines count as parallel, the point is then
// zero) and clipped (a coordinate saturated to the coordinate range).
// The csr_ port writes the parallel threshold, the largest denominator magnitude
// treated as parallel; write it only while no transfer is in flight.
// Throughput is one pair per cycle while rsp_ready stays high: the pipeline
// has five arithmetic stages, a setup stage, one restoring divider stage per
// quotient bit, and an output register, and every stage holds its own valid
// bit. Reset clears all valid bits and loads the threshold's reset value.
// When the receiver stalls, each stage holds only if the stage after it is full
// and held, so bubbles close up and new pairs keep entering until the whole
// pipeline is full; then req_ready drops. Nothing is lost or repeated.
`include "assert_macros.svh"

module line_intersection_point #(
   parameter int COORD_WIDTH = lip_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [COORD_WIDTH-1:0]         req_first_start_x,
   input  logic signed [COORD_WIDTH-1:0]         req_first_start_y,
   input  logic signed [COORD_WIDTH-1:0]         req_first_end_x,
   input  logic signed [COORD_WIDTH-1:0]         req_first_end_y,
   input  logic signed [COORD_WIDTH-1:0]         req_second_start_x,
   input  logic signed [COORD_WIDTH-1:0]         req_second_start_y,
   input  logic signed [COORD_WIDTH-1:0]         req_second_end_x,
   input  logic signed [COORD_WIDTH-1:0]         req_second_end_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [COORD_WIDTH-1:0]         rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_cross_y,
   output logic                                  rsp_found,
   output logic                                  rsp_clipped,
   input  logic                                  csr_wr_en,
   input  logic [lip_pkg::THR_WIDTH-1:0]         csr_wr_data
);

   localparam int W   = COORD_WIDTH;
   localparam int AW  = W + 1;       // point differences
   localparam int PW  = 2 * W;       // coordinate products
   localparam int CW  = 2 * W + 1;   // line offsets
   localparam int HP  = 2 * W + 2;   // products of (W+1)-bit operands
   localparam int DW  = 2 * W + 3;   // denominator
   localparam int NW  = 3 * W + 3;   // numerators
   localparam int NST = W + 7;       // register stages

   // Threshold register.
   logic [lip_pkg::THR_WIDTH-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= lip_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // Valid bits and per-stage advance. A stage loads when it is empty or the
   // next stage takes its current content.
   logic [NST-1:0] vld_ff;
   logic [NST:0]   adv;

   assign adv[NST] = rsp_ready;

   for (genvar k = 0; k < NST; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = adv[0];

   // Stage 1: line coefficients a and b, and the point products.
   logic signed [AW-1:0] s1_a1_ff, s1_b1_ff, s1_a2_ff, s1_b2_ff;
   logic signed [PW-1:0] s1_m03_ff, s1_m21_ff, s1_m47_ff, s1_m65_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_a1_ff  <= AW'(req_first_start_y) - AW'(req_first_end_y);
         s1_b1_ff  <= AW'(req_first_end_x) - AW'(req_first_start_x);
         s1_a2_ff  <= AW'(req_second_start_y) - AW'(req_second_end_y);
         s1_b2_ff  <= AW'(req_second_end_x) - AW'(req_second_start_x);
         s1_m03_ff <= PW'(req_first_start_x) * PW'(req_first_end_y);
         s1_m21_ff <= PW'(req_first_end_x) * PW'(req_first_start_y);
         s1_m47_ff <= PW'(req_second_start_x) * PW'(req_second_end_y);
         s1_m65_ff <= PW'(req_second_end_x) * PW'(req_second_start_y);
      end
   end

   // Stage 2: line offsets c, and the denominator products.
   logic signed [AW-1:0] s2_a1_ff, s2_b1_ff, s2_a2_ff, s2_b2_ff;
   logic signed [CW-1:0] s2_c1_ff, s2_c2_ff;
   logic signed [HP-1:0] s2_dp0_ff, s2_dp1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_a1_ff  <= s1_a1_ff;
         s2_b1_ff  <= s1_b1_ff;
         s2_a2_ff  <= s1_a2_ff;
         s2_b2_ff  <= s1_b2_ff;
         s2_c1_ff  <= CW'(s1_m03_ff) - CW'(s1_m21_ff);
         s2_c2_ff  <= CW'(s1_m47_ff) - CW'(s1_m65_ff);
         s2_dp0_ff <= HP'(s1_a1_ff) * HP'(s1_b2_ff);
         s2_dp1_ff <= HP'(s1_b1_ff) * HP'(s1_a2_ff);
      end
   end

   // Stage 3: the denominator, and numerator partial products with each
   // offset split into a low unsigned half and a high signed half.
   logic signed [AW-1:0] s2_c1_lo, s2_c2_lo, s2_c1_hi, s2_c2_hi;

   assign s2_c1_lo = $signed({1'b0, s2_c1_ff[W-1:0]});
   assign s2_c2_lo = $signed({1'b0, s2_c2_ff[W-1:0]});
   assign s2_c1_hi = s2_c1_ff[CW-1:W];
   assign s2_c2_hi = s2_c2_ff[CW-1:W];

   logic signed [DW-1:0] s3_d_ff;
   logic signed [HP-1:0] s3_b1c2l_ff, s3_b1c2h_ff, s3_c1b2l_ff, s3_c1b2h_ff;
   logic signed [HP-1:0] s3_c1a2l_ff, s3_c1a2h_ff, s3_a1c2l_ff, s3_a1c2h_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_d_ff     <= DW'(s2_dp0_ff) - DW'(s2_dp1_ff);
         s3_b1c2l_ff <= HP'(s2_b1_ff) * HP'(s2_c2_lo);
         s3_b1c2h_ff <= HP'(s2_b1_ff) * HP'(s2_c2_hi);
         s3_c1b2l_ff <= HP'(s2_c1_lo) * HP'(s2_b2_ff);
         s3_c1b2h_ff <= HP'(s2_c1_hi) * HP'(s2_b2_ff);
         s3_c1a2l_ff <= HP'(s2_c1_lo) * HP'(s2_a2_ff);
         s3_c1a2h_ff <= HP'(s2_c1_hi) * HP'(s2_a2_ff);
         s3_a1c2l_ff <= HP'(s2_a1_ff) * HP'(s2_c2_lo);
         s3_a1c2h_ff <= HP'(s2_a1_ff) * HP'(s2_c2_hi);
      end
   end

   // Stage 4: assemble the two numerators at full width.
   logic signed [NW-1:0] s4_n0_ff, s4_n1_ff;
   logic signed [DW-1:0] s4_d_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_n0_ff <= (NW'(s3_b1c2h_ff) <<< W) + NW'(s3_b1c2l_ff)
                   - (NW'(s3_c1b2h_ff) <<< W) - NW'(s3_c1b2l_ff);
         s4_n1_ff <= (NW'(s3_c1a2h_ff) <<< W) + NW'(s3_c1a2l_ff)
                   - (NW'(s3_a1c2h_ff) <<< W) - NW'(s3_a1c2l_ff);
         s4_d_ff  <= s3_d_ff;
      end
   end

   // Stage 5: magnitudes and quotient signs.
   logic [NW-1:0] s5_nm0_ff, s5_nm1_ff;
   logic [DW-1:0] s5_dm_ff;
   logic          s5_neg0_ff, s5_neg1_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_nm0_ff  <= s4_n0_ff[NW-1] ? NW'(-s4_n0_ff) : NW'(s4_n0_ff);
         s5_nm1_ff  <= s4_n1_ff[NW-1] ? NW'(-s4_n1_ff) : NW'(s4_n1_ff);
         s5_dm_ff   <= s4_d_ff[DW-1] ? DW'(-s4_d_ff) : DW'(s4_d_ff);
         s5_neg0_ff <= s4_n0_ff[NW-1] ^ s4_d_ff[DW-1];
         s5_neg1_ff <= s4_n1_ff[NW-1] ^ s4_d_ff[DW-1];
      end
   end

   // Divider pipeline. Entry 0 is the setup stage (parallel test and the
   // check for a quotient of 2^W or more); entry k+1 holds the result of
   // the step that decides quotient bit W-1-k.
   logic [NW-1:0] dv_rem0_ff [0:W];
   logic [NW-1:0] dv_rem1_ff [0:W];
   logic [W-1:0]  dv_q0_ff   [0:W];
   logic [W-1:0]  dv_q1_ff   [0:W];
   logic [DW-1:0] dv_dm_ff   [0:W];
   logic          dv_par_ff  [0:W];
   logic          dv_ovf0_ff [0:W];
   logic          dv_ovf1_ff [0:W];
   logic          dv_neg0_ff [0:W];
   logic          dv_neg1_ff [0:W];

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         dv_rem0_ff[0] <= s5_nm0_ff;
         dv_rem1_ff[0] <= s5_nm1_ff;
         dv_q0_ff[0]   <= '0;
         dv_q1_ff[0]   <= '0;
         dv_dm_ff[0]   <= s5_dm_ff;
         dv_par_ff[0]  <= s5_dm_ff <= DW'(thr_ff);
         dv_ovf0_ff[0] <= s5_nm0_ff >= {s5_dm_ff, {W{1'b0}}};
         dv_ovf1_ff[0] <= s5_nm1_ff >= {s5_dm_ff, {W{1'b0}}};
         dv_neg0_ff[0] <= s5_neg0_ff;
         dv_neg1_ff[0] <= s5_neg1_ff;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_div
      localparam int BIT = W - 1 - k;
      logic [NW-1:0] dsh;
      logic [NW:0]   trial0, trial1;

      assign dsh    = NW'(dv_dm_ff[k]) << BIT;
      assign trial0 = {1'b0, dv_rem0_ff[k]} - {1'b0, dsh};
      assign trial1 = {1'b0, dv_rem1_ff[k]} - {1'b0, dsh};

      always_ff @(posedge clock) begin
         if (adv[6+k]) begin
            dv_rem0_ff[k+1] <= trial0[NW] ? dv_rem0_ff[k] : trial0[NW-1:0];
            dv_rem1_ff[k+1] <= trial1[NW] ? dv_rem1_ff[k] : trial1[NW-1:0];
            dv_q0_ff[k+1]   <= dv_q0_ff[k] | (W'(!trial0[NW]) << BIT);
            dv_q1_ff[k+1]   <= dv_q1_ff[k] | (W'(!trial1[NW]) << BIT);
            dv_dm_ff[k+1]   <= dv_dm_ff[k];
            dv_par_ff[k+1]  <= dv_par_ff[k];
            dv_ovf0_ff[k+1] <= dv_ovf0_ff[k];
            dv_ovf1_ff[k+1] <= dv_ovf1_ff[k];
            dv_neg0_ff[k+1] <= dv_neg0_ff[k];
            dv_neg1_ff[k+1] <= dv_neg1_ff[k];
         end
      end
   end

   // Output stage: saturate, apply the sign, zero the fields when parallel.
   // A positive quotient clips above 2^(W-1)-1, a negative one above 2^(W-1).
   logic [W-1:0] q0, q1, sat0, sat1;
   logic         clip0, clip1;

   assign q0    = dv_q0_ff[W];
   assign q1    = dv_q1_ff[W];
   assign clip0 = dv_ovf0_ff[W] || (q0[W-1] && (!dv_neg0_ff[W] || (|q0[W-2:0])));
   assign clip1 = dv_ovf1_ff[W] || (q1[W-1] && (!dv_neg1_ff[W] || (|q1[W-2:0])));
   assign sat0  = clip0 ? {dv_neg0_ff[W], {(W-1){!dv_neg0_ff[W]}}} : q0;
   assign sat1  = clip1 ? {dv_neg1_ff[W], {(W-1){!dv_neg1_ff[W]}}} : q1;

   logic signed [W-1:0] out_x_ff, out_y_ff;
   logic                out_found_ff, out_clip_ff;

   always_ff @(posedge clock) begin
      if (adv[NST-1]) begin
         if (dv_par_ff[W]) begin
            out_x_ff     <= '0;
            out_y_ff     <= '0;
            out_found_ff <= 1'b0;
            out_clip_ff  <= 1'b0;
         end else begin
            out_x_ff     <= dv_neg0_ff[W] ? $signed(-sat0) : $signed(sat0);
            out_y_ff     <= dv_neg1_ff[W] ? $signed(-sat1) : $signed(sat1);
            out_found_ff <= 1'b1;
            out_clip_ff  <= clip0 || clip1;
         end
      end
   end

   assign rsp_valid   = vld_ff[NST-1];
   assign rsp_cross_x = out_x_ff;
   assign rsp_cross_y = out_y_ff;
   assign rsp_found   = out_found_ff;
   assign rsp_clipped = out_clip_ff;

   // A parallel result carries all-zero fields.
   `ASSERT_IMPLY(a_par_zero, clock, reset, rsp_valid && !rsp_found,
      rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_clipped)
   // Saturation is only reported together with a found point.
   `ASSERT_IMPLY(a_clip_found, clock, reset, rsp_valid && rsp_clipped, rsp_found)
   // An accepted pair always occupies the first stage in the next cycle.
   `ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, vld_ff[0])

endmodule

>>> test/line_intersection_point_tb.sv
// Self-checking testbench for the line intersection pipeline.
module line_intersection_point_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = lip_pkg::COORD_WIDTH_DEF;
   // Cycles without any transfer before the run is declared hung.
   localparam int HANG_LIMIT = 4000;
   // Pipeline latency plus some margin, used for the idle pause and the drain.
   localparam int DRAIN_CYCLES = CW + 7 + 20;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [255:0] wide_type;

   // One expected crossing result.
   typedef struct packed {
      coord_type cross_x;
      coord_type cross_y;
      logic      found;
      logic      clipped;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_pts [8];
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   coord_type rsp_cross_x;
   coord_type rsp_cross_y;
   logic      rsp_found;
   logic      rsp_clipped;
   logic      csr_wr_en = 1'b0;
   logic [lip_pkg::THR_WIDTH-1:0] csr_wr_data = '0;

   // The testbench's copy of the parallel threshold register.
   logic [lip_pkg::THR_WIDTH-1:0] parallel_thr = lip_pkg::THR_RESET;

   crossing_type pending_crossings [$];
   int           mismatch_count = 0;
   int           crossings_seen = 0;
   int           found_seen = 0;
   int           clipped_seen = 0;
   int           idle_cycles = 0;
   bit           sender_idles = 1'b1;
   bit           receiver_idles = 1'b1;
   int           rsp_hold = 0;

   initial begin
      for (int i = 0; i < 8; i++) req_pts[i] = '0;
   end

   always #4 clock = ~clock;

   line_intersection_point dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_first_start_x  (req_pts[0]),
      .req_first_start_y  (req_pts[1]),
      .req_first_end_x    (req_pts[2]),
      .req_first_end_y    (req_pts[3]),
      .req_second_start_x (req_pts[4]),
      .req_second_start_y (req_pts[5]),
      .req_second_end_x   (req_pts[6]),
      .req_second_end_y   (req_pts[7]),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cross_x        (rsp_cross_x),
      .rsp_cross_y        (rsp_cross_y),
      .rsp_found          (rsp_found),
      .rsp_clipped        (rsp_clipped),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Saturating, truncating quotient of two exact wide values.
   function automatic coord_type divide_clamped(wide_type num, wide_type den, inout logic clip);
      wide_type q;
      q = num / den;
      if (q > wide_type'(64'sd2147483647)) begin
         clip = 1'b1;
         return coord_type'(32'h7FFF_FFFF);
      end
      if (q < -wide_type'(64'sd2147483648)) begin
         clip = 1'b1;
         return coord_type'(32'h8000_0000);
      end
      return coord_type'(q[CW-1:0]);
   endfunction

   // Crosses the two homogeneous lines and divides out the third component.
   function automatic crossing_type predict_crossing(coord_type pts [8],
                                                     logic [lip_pkg::THR_WIDTH-1:0] thr);
      wide_type p [8];
      wide_type a1, b1, c1, a2, b2, c2, n0, n1, den, mag;
      crossing_type r;
      logic clip;
      for (int i = 0; i < 8; i++) p[i] = pts[i];
      a1 = p[1] - p[3];
      b1 = p[2] - p[0];
      c1 = p[0] * p[3] - p[2] * p[1];
      a2 = p[5] - p[7];
      b2 = p[6] - p[4];
      c2 = p[4] * p[7] - p[6] * p[5];
      n0 = b1 * c2 - c1 * b2;
      n1 = c1 * a2 - a1 * c2;
      den = a1 * b2 - b1 * a2;
      mag = (den < 0) ? -den : den;
      r = '0;
      clip = 1'b0;
      // At or below the threshold the lines count as parallel and all fields are zero.
      if (mag <= wide_type'({224'b0, thr})) return r;
      r.cross_x = divide_clamped(n0, den, clip);
      r.cross_y = divide_clamped(n1, den, clip);
      r.found   = 1'b1;
      r.clipped = clip;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
      mismatch_count++;
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
               crossings_seen);
   endtask

   // Sends one line pair. A random gap may come first; valid stays up until
   // the transfer, and the expectation is queued at the accepting edge.
   task automatic send_pair(coord_type pts [8]);
      int gap;
      gap = sender_idles ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 8; i++) req_pts[i] <= pts[i];
      do @(posedge clock); while (!req_ready);
      pending_crossings.push_back(predict_crossing(pts, parallel_thr));
   endtask

   // Drops valid at once, waits for every queued result, then lets the
   // pipeline empty out.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes happen only with the pipeline empty.
   task automatic write_threshold(logic [lip_pkg::THR_WIDTH-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      parallel_thr = value;
      csr_wr_en <= 1'b0;
   endtask

   // Random coordinate: full range, small integers, or small fractions.
   function automatic coord_type random_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(0, 200)) - 100) <<< 16;
         default: return coord_type'($signed($urandom_range(0, 32'h0004_0000))
                                     - 32'sh0002_0000);
      endcase
   endfunction

   // Builds one random line pair; some pairs are parallel or nearly so.
   task automatic random_pair(output coord_type pts [8]);
      int mode, shape;
      coord_type dx, dy;
      mode  = $urandom_range(0, 2);
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) pts[i] = random_coord(mode);
      if (shape == 0) begin
         // Second line parallel to the first, maybe off by one unit.
         dx = pts[2] - pts[0];
         dy = pts[3] - pts[1];
         pts[6] = pts[4] + dx + coord_type'($urandom_range(0, 2)) - 1;
         pts[7] = pts[5] + dy;
      end else if (shape == 1) begin
         // Degenerate first line.
         pts[2] = pts[0];
         pts[3] = pts[1];
      end
   endtask

   task automatic send_points(coord_type a, coord_type b, coord_type c, coord_type d,
                              coord_type e, coord_type f, coord_type g, coord_type h);
      coord_type pts [8];
      pts = '{a, b, c, d, e, f, g, h};
      send_pair(pts);
   endtask

   localparam coord_type ONE  = 32'sh0001_0000;
   localparam coord_type MAXC = 32'sh7FFF_FFFF;
   localparam coord_type MINC = 32'sh8000_0000;

   task automatic test_directed();
      // Axis crossing at the origin, then an offset crossing.
      send_points(-ONE, 0, ONE, 0, 0, -ONE, 0, ONE);
      send_points(0, 0, 4 * ONE, 4 * ONE, 0, 4 * ONE, 4 * ONE, 0);
      // Exactly parallel lines and a degenerate line.
      send_points(0, 0, ONE, ONE, 0, ONE, ONE, 2 * ONE);
      send_points(ONE, ONE, ONE, ONE, 0, 0, ONE, 0);
      // Extremes of every field.
      send_points(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
      send_points(MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC);
      send_points(MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC);
      send_points(-1, -1, 1, 1, -1, 1, 1, -1);
      // Nearly parallel lines whose crossing lies far away and saturates.
      send_points(0, 0, ONE, 0, 0, ONE, ONE, ONE + 1);
      send_points(0, 0, ONE, 0, 0, -ONE, ONE, -ONE - 1);
      send_points(MINC, 0, MAXC, 1, MINC, 2, MAXC, 2);
      send_points(0, MAXC, 1, MINC, 3, MAXC, 3, MINC);
      // Tiny denominators around the reset threshold.
      send_points(0, 0, 1, 0, 0, 0, 0, 42950);
      send_points(0, 0, 1, 0, 0, 0, 0, 42951);
   endtask

   task automatic test_threshold();
      coord_type pts [8];
      logic [lip_pkg::THR_WIDTH-1:0] values [4];
      values = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000};
      foreach (values[v]) begin
         write_threshold(values[v]);
         send_points(0, 0, 1, 0, 0, 0, 0, 1);
         send_points(0, 0, ONE, 0, 0, 0, 0, ONE);
         send_points(0, 0, ONE, 0, 0, 0, 0, ONE + 1);
         send_points(0, 0, ONE, ONE, 0, ONE, ONE, 2 * ONE);
         for (int i = 0; i < 20; i++) begin
            random_pair(pts);
            send_pair(pts);
         end
      end
      write_threshold(lip_pkg::THR_RESET);
   endtask

   task automatic test_random(int count);
      coord_type pts [8];
      for (int i = 0; i < count; i++) begin
         // Stretches without idling on either side, redrawn at random every 100 pairs.
         if (i % 100 == 0) begin
            sender_idles   = ($urandom_range(0, 2) != 0);
            receiver_idles = ($urandom_range(0, 2) != 0);
         end
         random_pair(pts);
         send_pair(pts);
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // The sender holds off until every result is back, then bursts.
   task automatic test_pause_then_burst();
      coord_type pts [8];
      wait_idle();
      sender_idles = 1'b0;
      for (int i = 0; i < 60; i++) begin
         random_pair(pts);
         send_pair(pts);
      end
      sender_idles = 1'b1;
   endtask

   // Result side: random stalls drawn after each transfer.
   always @(posedge clock) begin
      if (rsp_ready && rsp_valid) begin
         int h;
         h = receiver_idles ? $urandom_range(0, 4) : 0;
         if (h != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold = h - 1;
         end
      end else if (!rsp_ready && !reset) begin
         if (rsp_hold == 0) rsp_ready <= 1'b1;
         else rsp_hold--;
      end
   end

   // Checks each result transfer against the oldest expectation, and
   // watches for a pipeline that stops moving.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         crossing_type want;
         crossings_seen++;
         if (pending_crossings.size() == 0) begin
            mismatch_count++;
            $display("MISMATCH: result %0d arrived with nothing expected", crossings_seen);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_cross_x !== want.cross_x)
               report_mismatch("cross_x", rsp_cross_x, want.cross_x);
            if (rsp_cross_y !== want.cross_y)
               report_mismatch("cross_y", rsp_cross_y, want.cross_y);
            if (rsp_found !== want.found)
               report_mismatch("found", CW'(rsp_found), CW'(want.found));
            if (rsp_clipped !== want.clipped)
               report_mismatch("clipped", CW'(rsp_clipped), CW'(want.clipped));
            if (want.found) found_seen++;
            if (want.clipped) clipped_seen++;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_threshold();
      test_random(400);
      test_pause_then_burst();
      test_random(60);
      wait_idle();
      if (pending_crossings.size() != 0) mismatch_count++;
      $display("Covered %0d results (%0d found, %0d clipped) over five thresholds,",
               crossings_seen, found_seen, clipped_seen);
      $display("with random stalls on both channels and a burst after a full drain.");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lip_pkg.sv
rtl/core/line_intersection_point.sv
test/line_intersection_point_tb.sv
